// ===== rtl/knca_pkg.sv =====
// Package for the k-means nearest-center block: payload types, chain types
// and fixed widths. Used by the cell, the top level and the port checker.
`timescale 1ns / 1ps

package knca_pkg;

    localparam int COORD_W = 16;
    localparam int DIMS    = 8;
    localparam int DIM_W   = 3;
    localparam int IDX_W   = 6;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int DIST_W  = PROD_W + DIM_W;
    localparam int ACT_W   = 7;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = 35'd34358689800;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic [ACT_W-1:0]   act_t;

    typedef struct packed {
        logic   mode;
        idx_t   center_index;
        coord_t coord_0;
        coord_t coord_1;
        coord_t coord_2;
        coord_t coord_3;
        coord_t coord_4;
        coord_t coord_5;
        coord_t coord_6;
        coord_t coord_7;
    } req_t;

    typedef struct packed {
        idx_t  nearest_index;
        dist_t min_sq_dist;
    } rsp_t;

    // One coordinate of the point walking down the chain.
    typedef struct packed {
        logic   vld;
        dim_t   dim;
        coord_t coord;
    } tok_t;

    // Center write broadcast to every cell.
    typedef struct packed {
        logic                   en;
        idx_t                   idx;
        coord_t [DIMS-1:0]      coords;
    } load_t;

    // Best match so far, handed from cell to cell.
    typedef struct packed {
        logic  vld;
        idx_t  idx;
        dist_t sq_dist;
    } best_t;

endpackage

// ===== rtl/knca_cell.sv =====
// One cell of the center chain: holds one center, accumulates the squared
// distance one coordinate per cycle and merges with the best from upstream.
// Depends on knca_pkg.
`timescale 1ns / 1ps

module knca_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  knca_pkg::load_t ld,
    input  knca_pkg::act_t  active_centers,
    input  knca_pkg::tok_t  tok_in,
    output knca_pkg::tok_t  tok_out,
    input  knca_pkg::best_t best_in,
    output knca_pkg::best_t best_out
);

    localparam logic [7:0] IDX_L = 8'(IDX);

    knca_pkg::coord_t center_reg [knca_pkg::DIMS];

    knca_pkg::tok_t tok_reg;

    logic a_vld_reg, a_first_reg, a_last_reg;
    logic b_vld_reg, b_first_reg, b_last_reg;
    logic done_reg;
    logic best_vld_reg;

    knca_pkg::coord_t            sel;
    knca_pkg::coord_t            diff_next;
    knca_pkg::coord_t            diff_reg;
    logic [knca_pkg::PROD_W-1:0] prod_reg;
    knca_pkg::dist_t             acc_reg;
    knca_pkg::dist_t             acc_next;
    knca_pkg::idx_t              best_idx_reg;
    knca_pkg::dist_t             best_dist_reg;

    logic tok_first, tok_last;
    logic active, take, load_hit;

    always_comb
    begin
        sel       = center_reg[tok_in.dim];
        diff_next = (tok_in.coord >= sel) ? (tok_in.coord - sel) : (sel - tok_in.coord);
        tok_first = (tok_in.dim == '0);
        tok_last  = (tok_in.dim == knca_pkg::DIM_W'(knca_pkg::DIMS - 1));
        acc_next  = b_first_reg ? knca_pkg::DIST_W'(prod_reg)
                                : acc_reg + knca_pkg::DIST_W'(prod_reg);
        active    = (IDX_L < {1'b0, active_centers});
        take      = (IDX == 0) || (active && (acc_reg < best_in.sq_dist));
        load_hit  = ld.en && ({2'b00, ld.idx} == IDX_L);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg      <= '0;
            a_vld_reg    <= 1'b0;
            a_first_reg  <= 1'b0;
            a_last_reg   <= 1'b0;
            b_vld_reg    <= 1'b0;
            b_first_reg  <= 1'b0;
            b_last_reg   <= 1'b0;
            done_reg     <= 1'b0;
            best_vld_reg <= 1'b0;
        end
        else
        begin
            tok_reg      <= tok_in;
            a_vld_reg    <= tok_in.vld;
            a_first_reg  <= tok_in.vld && tok_first;
            a_last_reg   <= tok_in.vld && tok_last;
            b_vld_reg    <= a_vld_reg;
            b_first_reg  <= a_first_reg;
            b_last_reg   <= a_last_reg;
            done_reg     <= b_vld_reg && b_last_reg;
            best_vld_reg <= done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            for (int d = 0; d < knca_pkg::DIMS; d++)
            begin
                center_reg[d] <= ld.coords[d];
            end
        end
        diff_reg <= diff_next;
        prod_reg <= knca_pkg::PROD_W'(diff_reg) * knca_pkg::PROD_W'(diff_reg);
        if (b_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (done_reg)
        begin
            best_idx_reg  <= take ? knca_pkg::idx_t'(IDX) : best_in.idx;
            best_dist_reg <= take ? acc_reg : best_in.sq_dist;
        end
    end

    assign tok_out  = tok_reg;
    assign best_out = '{vld: best_vld_reg, idx: best_idx_reg, sq_dist: best_dist_reg};

endmodule

// ===== rtl/kmeans_nearest_center_assign.sv =====
// Top level of the k-means nearest-center block: controller, output register
// and the chain of knca_cell instances. Depends on knca_pkg and knca_cell.
// Use:
//   req channel (req_valid/req_stall/req): mode 0 loads the eight coordinates
//   of one center into slot center_index, with no result.
//   Mode 1 classifies a point against centers 0..active_centers-1.
//   rsp channel (rsp_valid/rsp_stall/rsp): one item per classify, the index
//   of the nearest center (lowest on ties) and its squared distance.
//   cfg_wr_en/cfg_wr_data: write active_centers (0 acts as 1, values above
//   MAX_CENTERS as MAX_CENTERS); write only while the block is idle.
// Timing:
//   The point enters the chain one coordinate per cycle and moves one cell
//   per cycle; each cell has a distance pipe and a compare stage. A result
//   is shown after the point has passed the whole chain. One classify is in
//   flight at a time, so the next classify item is held off until the
//   result of the last one is taken.
// Reset clears control state and sets active_centers to 64; center storage
// is undefined until loaded. While rsp is stalled, the result holds, loads
// are still taken, and the next classify waits until the result is taken.
`timescale 1ns / 1ps

module kmeans_nearest_center_assign #(
    parameter int MAX_CENTERS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  knca_pkg::req_t       req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output knca_pkg::rsp_t       rsp,
    input  logic                 cfg_wr_en,
    input  knca_pkg::act_t       cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;

    knca_pkg::dim_t  dim_cnt_reg, dim_cnt_next;
    knca_pkg::tok_t  tok_reg, tok_next;
    knca_pkg::act_t  active_reg, active_next;
    logic            rsp_valid_reg, rsp_valid_next;
    knca_pkg::rsp_t  rsp_reg;

    knca_pkg::coord_t [knca_pkg::DIMS-1:0] req_coords;
    knca_pkg::coord_t [knca_pkg::DIMS-1:0] point_reg;

    knca_pkg::load_t ld;
    knca_pkg::tok_t  tok_chain  [MAX_CENTERS+1];
    knca_pkg::best_t best_chain [MAX_CENTERS+1];
    knca_pkg::best_t best_last;

    logic req_accept;
    logic classify_accept;

    always_comb
    begin
        req_coords[0] = req.coord_0;
        req_coords[1] = req.coord_1;
        req_coords[2] = req.coord_2;
        req_coords[3] = req.coord_3;
        req_coords[4] = req.coord_4;
        req_coords[5] = req.coord_5;
        req_coords[6] = req.coord_6;
        req_coords[7] = req.coord_7;
    end

    assign req_stall = !((state_reg == ST_IDLE) &&
                         ((req.mode == knca_pkg::MODE_LOAD) || !rsp_valid_reg));
    assign req_accept      = req_valid && !req_stall;
    assign classify_accept = req_accept && (req.mode == knca_pkg::MODE_CLASSIFY);

    assign ld = '{en: req_accept && (req.mode == knca_pkg::MODE_LOAD),
                  idx: req.center_index,
                  coords: req_coords};

    assign best_last = best_chain[MAX_CENTERS];

    always_comb
    begin
        state_next     = state_reg;
        dim_cnt_next   = dim_cnt_reg;
        tok_next       = '{vld: 1'b0, dim: dim_cnt_reg, coord: point_reg[dim_cnt_reg]};
        active_next    = cfg_wr_en ? cfg_wr_data : active_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (best_last.vld)
        begin
            rsp_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (classify_accept)
                begin
                    state_next   = ST_FEED;
                    dim_cnt_next = knca_pkg::DIM_W'(1);
                    tok_next     = '{vld: 1'b1, dim: '0, coord: req.coord_0};
                end
            end
            ST_FEED:
            begin
                tok_next     = '{vld: 1'b1, dim: dim_cnt_reg, coord: point_reg[dim_cnt_reg]};
                dim_cnt_next = dim_cnt_reg + 1'b1;
                if (dim_cnt_reg == knca_pkg::DIM_W'(knca_pkg::DIMS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (best_last.vld)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dim_cnt_reg   <= '0;
            tok_reg       <= '0;
            active_reg    <= knca_pkg::ACT_W'(64);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dim_cnt_reg   <= dim_cnt_next;
            tok_reg       <= tok_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (classify_accept)
        begin
            point_reg <= req_coords;
        end
        if (best_last.vld)
        begin
            rsp_reg <= '{nearest_index: best_last.idx, min_sq_dist: best_last.sq_dist};
        end
    end

    assign tok_chain[0]  = tok_reg;
    assign best_chain[0] = '0;

    for (genvar i = 0; i < MAX_CENTERS; i++)
    begin : g_cell
        knca_cell #(
            .IDX (i)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ld             (ld),
            .active_centers (active_reg),
            .tok_in         (tok_chain[i]),
            .tok_out        (tok_chain[i+1]),
            .best_in        (best_chain[i]),
            .best_out       (best_chain[i+1])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/knca_checker.sv =====
// Port-level checker for kmeans_nearest_center_assign, attached by bind.
// Depends on knca_pkg.
`timescale 1ns / 1ps

module knca_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input knca_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input knca_pkg::rsp_t rsp
);

    logic classify_acc;
    assign classify_acc = req_valid && !req_stall && (req.mode == knca_pkg::MODE_CLASSIFY);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    a_busy_after_classify: assert property (@(posedge clk) disable iff (!rst_n)
        classify_acc |=> req_stall && !rsp_valid)
        else $error("classify item not held off or result appeared too early");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall |=> !rsp_valid)
        else $error("second result followed a taken result");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.min_sq_dist <= knca_pkg::DIST_MAX)
        else $error("distance out of range");

endmodule

bind kmeans_nearest_center_assign knca_checker u_knca_checker (.*);

// ===== verif/tb_kmeans_nearest_center_assign.sv =====
// Self-checking testbench for kmeans_nearest_center_assign: directed table, then random
// phases under varied idling, checked against an in-bench nearest-center predictor.
// Depends on knca_pkg and the kmeans_nearest_center_assign RTL.
`timescale 1ns / 1ps

module tb_kmeans_nearest_center_assign;

    localparam int NUM_CENTERS   = 64;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef knca_pkg::coord_t [knca_pkg::DIMS-1:0] point_t;
    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t      kind;
        knca_pkg::act_t act;
        knca_pkg::req_t item;
        logic           typed;
        knca_pkg::rsp_t typed_rsp;
    } row_t;

    logic           clk;
    logic           rst_n       = 1'b0;
    logic           req_valid   = 1'b0;
    logic           req_stall;
    knca_pkg::req_t req         = '0;
    logic           rsp_valid;
    logic           rsp_stall   = 1'b0;
    knca_pkg::rsp_t rsp;
    logic           cfg_wr_en   = 1'b0;
    knca_pkg::act_t cfg_wr_data = '0;

    point_t  center_store [NUM_CENTERS];
    logic [NUM_CENTERS-1:0] center_loaded = '0;
    knca_pkg::act_t active_setting = knca_pkg::act_t'(64);
    knca_pkg::rsp_t expected_assignments [$];
    row_t    directed_rows [$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    longint  cycle_count    = 0;

    kmeans_nearest_center_assign #(
        .MAX_CENTERS(NUM_CENTERS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic point_t splat(knca_pkg::coord_t v);
        point_t p;
        for (int d = 0; d < knca_pkg::DIMS; d++)
            p[d] = v;
        return p;
    endfunction

    function automatic knca_pkg::req_t make_req(logic mode, knca_pkg::idx_t idx, point_t p);
        knca_pkg::req_t r;
        r.mode         = mode;
        r.center_index = idx;
        r.coord_0      = p[0];
        r.coord_1      = p[1];
        r.coord_2      = p[2];
        r.coord_3      = p[3];
        r.coord_4      = p[4];
        r.coord_5      = p[5];
        r.coord_6      = p[6];
        r.coord_7      = p[7];
        return r;
    endfunction

    function automatic point_t point_of(knca_pkg::req_t r);
        return {r.coord_7, r.coord_6, r.coord_5, r.coord_4,
                r.coord_3, r.coord_2, r.coord_1, r.coord_0};
    endfunction

    function automatic point_t extreme_point();
        point_t p;
        for (int d = 0; d < knca_pkg::DIMS; d++)
            case ($urandom_range(2))
                0:       p[d] = '0;
                1:       p[d] = '1;
                default: p[d] = knca_pkg::coord_t'(16'h8000);
            endcase
        return p;
    endfunction

    function automatic point_t random_point();
        point_t p;
        for (int d = 0; d < knca_pkg::DIMS; d++)
            p[d] = knca_pkg::coord_t'($urandom);
        return p;
    endfunction

    function automatic int searched_count();
        if (active_setting == 0)
            return 1;
        if (active_setting > NUM_CENTERS)
            return NUM_CENTERS;
        return int'(active_setting);
    endfunction

    function automatic knca_pkg::dist_t squared_distance(point_t a, point_t b);
        knca_pkg::dist_t  sum;
        knca_pkg::coord_t diff;
        sum = '0;
        for (int d = 0; d < knca_pkg::DIMS; d++)
        begin
            diff = (a[d] >= b[d]) ? a[d] - b[d] : b[d] - a[d];
            sum  = sum + knca_pkg::dist_t'(diff) * knca_pkg::dist_t'(diff);
        end
        return sum;
    endfunction

    function automatic knca_pkg::rsp_t closest_center(point_t pt);
        knca_pkg::rsp_t  best;
        knca_pkg::dist_t d;
        best.nearest_index = '0;
        best.min_sq_dist   = squared_distance(pt, center_store[0]);
        for (int j = 1; j < searched_count(); j++)
        begin
            d = squared_distance(pt, center_store[j]);
            if (d < best.min_sq_dist)
            begin
                best.nearest_index = knca_pkg::idx_t'(j);
                best.min_sq_dist   = d;
            end
        end
        return best;
    endfunction

    // Advance the predictor by one accepted item.
    function automatic void track_item(knca_pkg::req_t it, logic typed,
                                       knca_pkg::rsp_t typed_rsp);
        if (it.mode == knca_pkg::MODE_LOAD)
        begin
            center_store[it.center_index]  = point_of(it);
            center_loaded[it.center_index] = 1'b1;
        end
        else if (typed)
            expected_assignments.push_back(typed_rsp);
        else
            expected_assignments.push_back(closest_center(point_of(it)));
    endfunction

    function automatic void add_cfg(int v);
        row_t r;
        r.kind      = ROW_CFG;
        r.act       = knca_pkg::act_t'(v);
        r.item      = '0;
        r.typed     = 1'b0;
        r.typed_rsp = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_load(int idx, point_t p);
        row_t r;
        r.kind      = ROW_ITEM;
        r.act       = '0;
        r.item      = make_req(knca_pkg::MODE_LOAD, knca_pkg::idx_t'(idx), p);
        r.typed     = 1'b0;
        r.typed_rsp = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_classify(point_t p, logic typed, int eidx,
                                         knca_pkg::dist_t edist);
        row_t r;
        r.kind                    = ROW_ITEM;
        r.act                     = '0;
        r.item                    = make_req(knca_pkg::MODE_CLASSIFY, '0, p);
        r.typed                   = typed;
        r.typed_rsp.nearest_index = knca_pkg::idx_t'(eidx);
        r.typed_rsp.min_sq_dist   = edist;
        directed_rows.push_back(r);
    endfunction

    // Build a well-formed item: never search a center that was not loaded.
    function automatic knca_pkg::req_t random_item();
        int             n;
        int             first_gap;
        int             pick;
        int             spread;
        int             v;
        int             k;
        knca_pkg::idx_t slot;
        point_t         base;
        point_t         p;
        n         = searched_count();
        first_gap = -1;
        for (int j = n - 1; j >= 0; j--)
            if (!center_loaded[j])
                first_gap = j;
        pick = $urandom_range(9);
        if (first_gap < 0 && $urandom_range(99) < 55)
        begin
            if (pick < 4)
            begin
                base = center_store[$urandom_range(n - 1)];
                case ($urandom_range(2))
                    0:       spread = 0;
                    1:       spread = 15;
                    default: spread = 255;
                endcase
                for (int d = 0; d < knca_pkg::DIMS; d++)
                begin
                    v = int'(base[d]) + int'($urandom_range(2 * spread)) - spread;
                    if (v < 0)
                        v = 0;
                    if (v > 65535)
                        v = 65535;
                    p[d] = knca_pkg::coord_t'(v);
                end
            end
            else if (pick < 6)
                p = extreme_point();
            else
                p = random_point();
            return make_req(knca_pkg::MODE_CLASSIFY, knca_pkg::idx_t'($urandom), p);
        end
        if (first_gap >= 0 && $urandom_range(1) == 1)
            slot = knca_pkg::idx_t'(first_gap);
        else if ($urandom_range(9) < 7)
            slot = knca_pkg::idx_t'($urandom_range(n - 1));
        else
            slot = knca_pkg::idx_t'($urandom_range(NUM_CENTERS - 1));
        k = $urandom_range(NUM_CENTERS - 1);
        if (pick < 2 && center_loaded[k])
            p = center_store[k];
        else if (pick < 3)
            p = extreme_point();
        else
            p = random_point();
        return make_req(knca_pkg::MODE_LOAD, slot, p);
    endfunction

    task automatic drive_item(knca_pkg::req_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Drain all results, let the chain settle, then write the register.
    task automatic write_active(knca_pkg::act_t v);
        req_valid <= 1'b0;
        while (expected_assignments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        active_setting  = v;
    endtask

    task automatic run_phase(knca_pkg::act_t act, int idle_pct, int stall_pct, int count);
        knca_pkg::req_t it;
        write_active(act);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
        begin
            it = random_item();
            drive_item(it);
            track_item(it, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        knca_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_assignments.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got index %0d distance %0d",
                         $time, rsp.nearest_index, rsp.min_sq_dist);
            end
            else
            begin
                want = expected_assignments.pop_front();
                if (rsp.nearest_index !== want.nearest_index)
                begin
                    mismatch_count++;
                    $display("%0t: nearest_index expected %0d got %0d",
                             $time, want.nearest_index, rsp.nearest_index);
                end
                if (rsp.min_sq_dist !== want.min_sq_dist)
                begin
                    mismatch_count++;
                    $display("%0t: min_sq_dist expected %0d got %0d",
                             $time, want.min_sq_dist, rsp.min_sq_dist);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("kmeans_nearest_center_assign test failed");
            $finish;
        end
    end

    initial
    begin
        for (int j = 0; j < NUM_CENTERS; j++)
            center_store[j] = '0;

        add_cfg(2);
        add_load(0, splat(16'h0000));
        add_load(1, splat(16'hFFFF));
        add_classify(splat(16'h0000), 1'b1, 0, '0);
        add_classify(splat(16'hFFFF), 1'b1, 1, '0);
        add_classify(splat(16'h8000), 1'b0, 0, '0);
        add_cfg(1);
        add_classify(splat(16'hFFFF), 1'b1, 0, knca_pkg::DIST_MAX);
        add_cfg(0);
        add_load(1, splat(16'h1234));
        add_classify(splat(16'h1234), 1'b0, 0, '0);
        add_cfg(3);
        add_load(2, splat(16'h1234));
        add_classify(splat(16'h1234), 1'b1, 1, '0);
        add_load(0, splat(16'h1000));
        add_load(1, splat(16'h3000));
        add_load(2, splat(16'h4000));
        add_classify(splat(16'h2000), 1'b0, 0, '0);
        add_load(63, point_t'({4{16'hAAAA, 16'h5555}}));
        add_load(42, point_t'({4{16'h5555, 16'hAAAA}}));
        add_load(21, splat(16'hFFFF));
        add_classify(point_t'({4{16'hAAAA, 16'h5555}}), 1'b0, 0, '0);
        add_classify(point_t'({16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE,
                               16'h0100, 16'h00FF, 16'hC3A5, 16'h3C5A}), 1'b0, 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_active(directed_rows[i].act);
            else
            begin
                drive_item(directed_rows[i].item);
                track_item(directed_rows[i].item, directed_rows[i].typed,
                           directed_rows[i].typed_rsp);
            end
        end

        run_phase(knca_pkg::act_t'(64), 0, 0, 400);
        run_phase(knca_pkg::act_t'(127), 87, 0, 300);
        run_phase(knca_pkg::act_t'(5), 0, 87, 300);
        run_phase(knca_pkg::act_t'(1), 14, 14, 300);
        run_phase(knca_pkg::act_t'(0), 0, 0, 150);
        run_phase(knca_pkg::act_t'($urandom_range(63, 2)), 14, 14, 250);
        run_phase(knca_pkg::act_t'(96), 0, 87, 200);

        req_valid <= 1'b0;
        while (expected_assignments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("kmeans_nearest_center_assign test passed");
        else
            $display("kmeans_nearest_center_assign test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/knca_pkg.sv
rtl/knca_cell.sv
rtl/kmeans_nearest_center_assign.sv
rtl/knca_checker.sv
verif/tb_kmeans_nearest_center_assign.sv
